>>> rtl/core/ecam_pkg.sv
// ---------------------------------------------------------------------------
// ecam_pkg: shared types and constants of the euler fly camera update unit
// angle constants in Q16.16 degrees, cordic table, config and result structs
// ---------------------------------------------------------------------------
package ecam_pkg;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [33:0] DEG89   = 34'sd5832704;
    localparam logic signed [33:0] DEG90   = 34'sd5898240;
    localparam logic signed [33:0] DEG180  = 34'sd11796480;
    localparam logic signed [33:0] DEG360  = 34'sd23592960;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic [14:0] UNIT_Q14 = 15'd16384;

    typedef enum logic [2:0] {
        FN_FORWARD  = 3'd0,
        FN_BACKWARD = 3'd1,
        FN_LEFT     = 3'd2,
        FN_RIGHT    = 3'd3,
        FN_MOUSE    = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        REG_MOVE_STEP  = 3'd0,
        REG_MOUSE_GAIN = 3'd1,
        REG_SCREEN_W   = 3'd2,
        REG_SCREEN_H   = 3'd3,
        REG_START_X    = 3'd4,
        REG_START_Y    = 3'd5,
        REG_START_Z    = 3'd6,
        REG_WORLD_UP   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [19:0] move_step;
        logic [15:0] mouse_gain;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] start_z;
        logic        world_up_sign;
    } cfg_t;

    typedef struct packed {
        logic ld_x;
        logic ld_y;
        logic ld_z;
    } pos_load_t;

    typedef struct packed {
        logic signed [15:0] up_z;
        logic signed [15:0] up_y;
        logic signed [15:0] up_x;
        logic signed [15:0] front_z;
        logic signed [15:0] front_y;
        logic signed [15:0] front_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } result_t;

    // arctangent of 2^-i in Q16.16 degrees
    function automatic logic signed [33:0] atan_deg(input logic [3:0] i);
        logic signed [33:0] v;
        unique case (i)
            4'd0:    v = 34'sd2949120;
            4'd1:    v = 34'sd1740967;
            4'd2:    v = 34'sd919879;
            4'd3:    v = 34'sd466945;
            4'd4:    v = 34'sd234379;
            4'd5:    v = 34'sd117303;
            4'd6:    v = 34'sd58666;
            4'd7:    v = 34'sd29335;
            4'd8:    v = 34'sd14668;
            4'd9:    v = 34'sd7334;
            4'd10:   v = 34'sd3667;
            4'd11:   v = 34'sd1833;
            4'd12:   v = 34'sd917;
            4'd13:   v = 34'sd458;
            4'd14:   v = 34'sd229;
            default: v = 34'sd115;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/ecam_mul.sv
// ---------------------------------------------------------------------------
// ecam_mul: shared signed multiplier
// one registered product per cycle, used by the multiply states of the sequencer
// ---------------------------------------------------------------------------
module ecam_mul (
    input  logic                                clk,
    input  logic signed [ecam_pkg::MUL_W-1:0]   mul_a,
    input  logic signed [ecam_pkg::MUL_W-1:0]   mul_b,
    output logic signed [ecam_pkg::PROD_W-1:0]  prod
);
    import ecam_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/ecam_regs.sv
// ---------------------------------------------------------------------------
// ecam_regs: configuration register file
// apb-style write and read of the eight camera settings
// ---------------------------------------------------------------------------
module ecam_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output ecam_pkg::cfg_t       cfg,
    output ecam_pkg::pos_load_t  pos_load
);
    import ecam_pkg::*;

    cfg_t      cfg_reg;
    pos_load_t pos_load_reg;
    logic      wr_en;
    reg_idx_t  widx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_step     <= 20'd13107;
            cfg_reg.mouse_gain    <= 16'd6554;
            cfg_reg.screen_width  <= 12'd800;
            cfg_reg.screen_height <= 12'd600;
            cfg_reg.start_x       <= '0;
            cfg_reg.start_y       <= '0;
            cfg_reg.start_z       <= '0;
            cfg_reg.world_up_sign <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_MOVE_STEP:  cfg_reg.move_step     <= pwdata[19:0];
                REG_MOUSE_GAIN: cfg_reg.mouse_gain    <= pwdata[15:0];
                REG_SCREEN_W:   cfg_reg.screen_width  <= pwdata[11:0];
                REG_SCREEN_H:   cfg_reg.screen_height <= pwdata[11:0];
                REG_START_X:    cfg_reg.start_x       <= pwdata;
                REG_START_Y:    cfg_reg.start_y       <= pwdata;
                REG_START_Z:    cfg_reg.start_z       <= pwdata;
                REG_WORLD_UP:   cfg_reg.world_up_sign <= pwdata[0];
                default:        cfg_reg.world_up_sign <= cfg_reg.world_up_sign;
            endcase
        end
    end

    // start writes also reload the live position in the cycle after the
    // write, so the start register already holds the new value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_load_reg <= '0;
        end
        else
        begin
            pos_load_reg.ld_x <= wr_en && (widx == REG_START_X);
            pos_load_reg.ld_y <= wr_en && (widx == REG_START_Y);
            pos_load_reg.ld_z <= wr_en && (widx == REG_START_Z);
        end
    end

    assign pos_load = pos_load_reg;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_MOVE_STEP:  prdata = {12'd0, cfg_reg.move_step};
            REG_MOUSE_GAIN: prdata = {16'd0, cfg_reg.mouse_gain};
            REG_SCREEN_W:   prdata = {20'd0, cfg_reg.screen_width};
            REG_SCREEN_H:   prdata = {20'd0, cfg_reg.screen_height};
            REG_START_X:    prdata = cfg_reg.start_x;
            REG_START_Y:    prdata = cfg_reg.start_y;
            REG_START_Z:    prdata = cfg_reg.start_z;
            REG_WORLD_UP:   prdata = {31'd0, cfg_reg.world_up_sign};
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/ecam_core.sv
// ---------------------------------------------------------------------------
// ecam_core: camera state and sequencer
// drives the shared multiplier, cordic, square root and divider steps
// ---------------------------------------------------------------------------
module ecam_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecam_pkg::cfg_t       cfg,
    input  ecam_pkg::pos_load_t  pos_load,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           func,
    input  logic [11:0]          mouse_x,
    input  logic [11:0]          mouse_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ecam_pkg::result_t    result
);
    import ecam_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE     = 18'b000000000000000001,
        ST_MOVE_MUL = 18'b000000000000000010,
        ST_MOVE_ADD = 18'b000000000000000100,
        ST_ANG_MUL  = 18'b000000000000001000,
        ST_ANG_ADD  = 18'b000000000000010000,
        ST_WRAP     = 18'b000000000000100000,
        ST_COR_INIT = 18'b000000000001000000,
        ST_COR_ITER = 18'b000000000010000000,
        ST_COR_DONE = 18'b000000000100000000,
        ST_VEC_MUL  = 18'b000000001000000000,
        ST_VEC_ADD  = 18'b000000010000000000,
        ST_SQ_MUL   = 18'b000000100000000000,
        ST_SQ_ADD   = 18'b000001000000000000,
        ST_SQRT     = 18'b000010000000000000,
        ST_DIV_INIT = 18'b000100000000000000,
        ST_DIV      = 18'b001000000000000000,
        ST_STORE    = 18'b010000000000000000,
        ST_OUT      = 18'b100000000000000000
    } state_t;

    state_t state_reg;

    logic [1:0]  idx_reg;
    logic [1:0]  vsel_reg;
    logic [2:0]  j_reg;
    logic [4:0]  step_reg;
    logic        neg_reg;
    func_t       func_reg;
    logic [11:0] mx_reg;
    logic [11:0] my_reg;

    logic [31:0]        pos_reg   [3];
    logic signed [31:0] yaw_reg;
    logic signed [31:0] pitch_reg;
    logic signed [15:0] front_reg [3];
    logic signed [15:0] right_reg [3];
    logic signed [15:0] up_reg    [3];

    logic signed [PROD_W-1:0] acc_reg;
    logic signed [33:0]       cx_reg;
    logic signed [33:0]       cy_reg;
    logic signed [33:0]       cz_reg;
    logic signed [33:0]       cos_reg [2];
    logic signed [33:0]       sin_reg [2];
    logic signed [33:0]       fv_reg  [3];
    logic signed [33:0]       rv_reg  [3];
    logic signed [33:0]       uv_reg  [3];
    logic [63:0]              sum_reg;
    logic [63:0]              sv_reg;
    logic [63:0]              sr_reg;
    logic [32:0]              m_reg;
    logic [47:0]              num_reg;
    logic [14:0]              q_reg;

    logic                     out_valid_reg;
    result_t                  result_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    ecam_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // shared datapath terms
    logic signed [15:0]       dir_k;
    logic                     move_neg;
    logic signed [33:0]       vk;
    logic signed [14:0]       d2;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] prod_half;
    logic signed [PROD_W-1:0] u1_sum;
    logic signed [33:0]       ang;
    logic signed [34:0]       pitch_sum;
    logic signed [33:0]       cdx;
    logic signed [33:0]       cdy;
    logic [63:0]              sq_bit;
    logic [63:0]              sq_try;
    logic [63:0]              sr_nxt;
    logic [63:0]              sv_nxt;
    logic [47:0]              div_sub;
    logic [14:0]              q_nxt;
    logic [47:0]              num_nxt;
    logic [33:0]              vmag;
    logic [14:0]              q_clamp;
    logic signed [15:0]       nrm_val;
    logic                     pos_out_full;

    assign dir_k    = func_reg[1] ? right_reg[idx_reg] : front_reg[idx_reg];
    assign move_neg = (func_reg == FN_BACKWARD) || (func_reg == FN_LEFT);

    always_comb
    begin
        unique case (vsel_reg)
            2'd0:    vk = fv_reg[idx_reg];
            2'd1:    vk = rv_reg[idx_reg];
            default: vk = uv_reg[idx_reg];
        endcase
    end

    // doubled offset from the screen centre
    assign d2 = (idx_reg == 2'd0)
        ? ($signed({3'd0, mx_reg}) * 15'sd2 - $signed({3'd0, cfg.screen_width}))
        : ($signed({3'd0, cfg.screen_height}) - $signed({3'd0, my_reg}) * 15'sd2);

    assign prod_rnd  = prod + PROD_W'(8192);
    assign prod_half = prod + PROD_W'(1);
    assign u1_sum    = acc_reg + prod;
    assign pitch_sum = 35'(pitch_reg) + 35'($signed(prod_half[34:1]));
    assign ang       = (idx_reg == 2'd0) ? 34'(yaw_reg) : 34'(pitch_reg);
    assign cdx       = cy_reg >>> step_reg;
    assign cdy       = cx_reg >>> step_reg;

    // one bit pair of the integer square root per cycle
    assign sq_bit = 64'd1 << {step_reg, 1'b0};
    assign sq_try = sr_reg + sq_bit;
    always_comb
    begin
        if (sv_reg >= sq_try)
        begin
            sv_nxt = sv_reg - sq_try;
            sr_nxt = (sr_reg >> 1) + sq_bit;
        end
        else
        begin
            sv_nxt = sv_reg;
            sr_nxt = sr_reg >> 1;
        end
    end

    // one quotient bit per cycle
    assign div_sub = {15'd0, m_reg} << step_reg[3:0];
    always_comb
    begin
        q_nxt   = q_reg;
        num_nxt = num_reg;
        if (num_reg >= div_sub)
        begin
            num_nxt          = num_reg - div_sub;
            q_nxt[step_reg[3:0]] = 1'b1;
        end
    end

    assign vmag    = vk[33] ? 34'(-vk) : 34'(vk);
    assign q_clamp = (q_reg > UNIT_Q14) ? UNIT_Q14 : q_reg;
    assign nrm_val = vk[33] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MOVE_MUL:
            begin
                mul_a = MUL_W'(dir_k);
                mul_b = $signed({14'd0, cfg.move_step});
            end
            ST_ANG_MUL:
            begin
                mul_a = MUL_W'(d2);
                mul_b = $signed({18'd0, cfg.mouse_gain});
            end
            ST_VEC_MUL:
            begin
                unique case (j_reg)
                    3'd0:    begin mul_a = cos_reg[0]; mul_b = cos_reg[1]; end
                    3'd1:    begin mul_a = sin_reg[0]; mul_b = cos_reg[1]; end
                    3'd2:    begin mul_a = rv_reg[2];  mul_b = -fv_reg[1]; end
                    3'd3:    begin mul_a = rv_reg[2];  mul_b = fv_reg[0];  end
                    3'd4:    begin mul_a = -rv_reg[0]; mul_b = fv_reg[2];  end
                    default: begin mul_a = rv_reg[0];  mul_b = fv_reg[1];  end
                endcase
            end
            ST_SQ_MUL:
            begin
                mul_a = vk;
                mul_b = vk;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pos_out_full = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            vsel_reg      <= '0;
            j_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            pos_reg[2]    <= '0;
            yaw_reg       <= -32'(DEG90);
            pitch_reg     <= '0;
            front_reg[0]  <= 16'sd0;
            front_reg[1]  <= 16'sd0;
            front_reg[2]  <= -16'sd16384;
            right_reg[0]  <= 16'sd16384;
            right_reg[1]  <= 16'sd0;
            right_reg[2]  <= 16'sd0;
            up_reg[0]     <= 16'sd0;
            up_reg[1]     <= 16'sd16384;
            up_reg[2]     <= 16'sd0;
        end
        else
        begin
            // a new result may replace one taken in the same cycle
            if (state_reg == ST_OUT && !pos_out_full)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pos_load.ld_x)
            begin
                pos_reg[0] <= cfg.start_x;
            end
            if (pos_load.ld_y)
            begin
                pos_reg[1] <= cfg.start_y;
            end
            if (pos_load.ld_z)
            begin
                pos_reg[2] <= cfg.start_z;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg <= '0;
                        priority if (func == FN_MOUSE)
                        begin
                            state_reg <= ST_ANG_MUL;
                        end
                        else if (func[2] == 1'b0)
                        begin
                            state_reg <= ST_MOVE_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_MOVE_MUL:
                begin
                    state_reg <= ST_MOVE_ADD;
                end
                ST_MOVE_ADD:
                begin
                    pos_reg[idx_reg] <= move_neg ? pos_reg[idx_reg] - prod_rnd[45:14]
                                                 : pos_reg[idx_reg] + prod_rnd[45:14];
                    idx_reg   <= idx_reg + 2'd1;
                    state_reg <= (idx_reg == 2'd2) ? ST_OUT : ST_MOVE_MUL;
                end
                ST_ANG_MUL:
                begin
                    state_reg <= ST_ANG_ADD;
                end
                ST_ANG_ADD:
                begin
                    if (idx_reg == 2'd0)
                    begin
                        acc_reg   <= PROD_W'(yaw_reg) + PROD_W'($signed(prod_half[34:1]))
                                   + PROD_W'(DEG180);
                        idx_reg   <= 2'd1;
                        state_reg <= ST_ANG_MUL;
                    end
                    else
                    begin
                        priority if (pitch_sum > 35'(DEG89))
                        begin
                            pitch_reg <= 32'(DEG89);
                        end
                        else if (pitch_sum < -35'(DEG89))
                        begin
                            pitch_reg <= -32'(DEG89);
                        end
                        else
                        begin
                            pitch_reg <= pitch_sum[31:0];
                        end
                        state_reg <= ST_WRAP;
                    end
                end
                ST_WRAP:
                begin
                    // yaw + 180 brought into one turn by repeated steps
                    priority if (acc_reg >= PROD_W'(DEG360))
                    begin
                        acc_reg <= acc_reg - PROD_W'(DEG360);
                    end
                    else if (acc_reg < 0)
                    begin
                        acc_reg <= acc_reg + PROD_W'(DEG360);
                    end
                    else
                    begin
                        yaw_reg   <= acc_reg[31:0] - 32'(DEG180);
                        idx_reg   <= 2'd0;
                        state_reg <= ST_COR_INIT;
                    end
                end
                ST_COR_INIT:
                begin
                    cx_reg   <= CORDIC_K;
                    cy_reg   <= '0;
                    step_reg <= '0;
                    priority if (ang > DEG90)
                    begin
                        cz_reg  <= ang - DEG180;
                        neg_reg <= 1'b1;
                    end
                    else if (ang < -DEG90)
                    begin
                        cz_reg  <= ang + DEG180;
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        cz_reg  <= ang;
                        neg_reg <= 1'b0;
                    end
                    state_reg <= ST_COR_ITER;
                end
                ST_COR_ITER:
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - cdx;
                        cy_reg <= cy_reg + cdy;
                        cz_reg <= cz_reg - atan_deg(step_reg[3:0]);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + cdx;
                        cy_reg <= cy_reg - cdy;
                        cz_reg <= cz_reg + atan_deg(step_reg[3:0]);
                    end
                    step_reg  <= step_reg + 5'd1;
                    state_reg <= (step_reg == 5'd15) ? ST_COR_DONE : ST_COR_ITER;
                end
                ST_COR_DONE:
                begin
                    cos_reg[idx_reg[0]] <= neg_reg ? -cx_reg : cx_reg;
                    sin_reg[idx_reg[0]] <= neg_reg ? -cy_reg : cy_reg;
                    if (idx_reg == 2'd0)
                    begin
                        idx_reg   <= 2'd1;
                        state_reg <= ST_COR_INIT;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_VEC_MUL;
                    end
                end
                ST_VEC_MUL:
                begin
                    state_reg <= ST_VEC_ADD;
                end
                ST_VEC_ADD:
                begin
                    unique case (j_reg)
                        3'd0:
                        begin
                            fv_reg[0] <= prod[63:30];
                        end
                        3'd1:
                        begin
                            fv_reg[2] <= prod[63:30];
                            fv_reg[1] <= sin_reg[1];
                            rv_reg[0] <= cfg.world_up_sign ? prod[63:30] : -prod[63:30];
                            rv_reg[1] <= '0;
                            rv_reg[2] <= cfg.world_up_sign ? -fv_reg[0] : fv_reg[0];
                        end
                        3'd2:
                        begin
                            uv_reg[0] <= prod[63:30];
                        end
                        3'd3:
                        begin
                            acc_reg <= prod;
                        end
                        3'd4:
                        begin
                            uv_reg[1] <= u1_sum[63:30];
                        end
                        default:
                        begin
                            uv_reg[2] <= prod[63:30];
                        end
                    endcase
                    j_reg <= j_reg + 3'd1;
                    if (j_reg == 3'd5)
                    begin
                        vsel_reg  <= 2'd0;
                        idx_reg   <= 2'd0;
                        sum_reg   <= '0;
                        state_reg <= ST_SQ_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_VEC_MUL;
                    end
                end
                ST_SQ_MUL:
                begin
                    state_reg <= ST_SQ_ADD;
                end
                ST_SQ_ADD:
                begin
                    sum_reg <= sum_reg + prod[63:0];
                    if (idx_reg == 2'd2)
                    begin
                        sv_reg    <= sum_reg + prod[63:0];
                        sr_reg    <= '0;
                        step_reg  <= 5'd31;
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQRT:
                begin
                    sv_reg   <= sv_nxt;
                    sr_reg   <= sr_nxt;
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd0)
                    begin
                        m_reg     <= sr_nxt[32:0];
                        idx_reg   <= 2'd0;
                        state_reg <= ST_DIV_INIT;
                    end
                end
                ST_DIV_INIT:
                begin
                    q_reg    <= '0;
                    step_reg <= 5'd14;
                    num_reg  <= {vmag[33:0], 14'd0} + 48'(m_reg >> 1);
                    // a zero-length vector normalizes to zero
                    state_reg <= (m_reg == '0) ? ST_STORE : ST_DIV;
                end
                ST_DIV:
                begin
                    q_reg    <= q_nxt;
                    num_reg  <= num_nxt;
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd0)
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    unique case (vsel_reg)
                        2'd0:    front_reg[idx_reg] <= nrm_val;
                        2'd1:    right_reg[idx_reg] <= nrm_val;
                        default: up_reg[idx_reg]    <= nrm_val;
                    endcase
                    if (idx_reg != 2'd2)
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_DIV_INIT;
                    end
                    else if (vsel_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        vsel_reg  <= vsel_reg + 2'd1;
                        idx_reg   <= 2'd0;
                        sum_reg   <= '0;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_OUT:
                begin
                    if (!pos_out_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item latch and result register carry no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            func_reg <= func_t'(func);
            mx_reg   <= mouse_x;
            my_reg   <= mouse_y;
        end
        if (state_reg == ST_OUT && !pos_out_full)
        begin
            result_reg.pos_x   <= pos_reg[0];
            result_reg.pos_y   <= pos_reg[1];
            result_reg.pos_z   <= pos_reg[2];
            result_reg.front_x <= front_reg[0];
            result_reg.front_y <= front_reg[1];
            result_reg.front_z <= front_reg[2];
            result_reg.up_x    <= up_reg[0];
            result_reg.up_y    <= up_reg[1];
            result_reg.up_z    <= up_reg[2];
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer took a second item");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_reg <= 32'(DEG89)) && (pitch_reg >= -32'(DEG89)))
        else $error("pitch outside clamp range");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (yaw_reg >= -32'(DEG180)) && (yaw_reg < 32'(DEG180)))
        else $error("yaw outside one turn");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (m_reg != '0))
        else $error("divide by zero length");

endmodule

>>> rtl/core/euler_fly_camera_update_unit.sv
// ---------------------------------------------------------------------------
// euler_fly_camera_update_unit: fly camera with yaw and pitch control
// top level with stream input, stream result and apb configuration
// ---------------------------------------------------------------------------
// usage:
//   each input item carries a move command (forward, backward, left, right)
//   or a mouse position. every item gives one result item: position, front
//   and up vectors after the step.
//   settings are to be written over the apb port while no item is in flight
//   (the block does not check); a start write reloads that position component.
// timing:
//   one item at a time, s_tready is high only while the sequencer is idle.
//   a move item uses three multiplies on the shared multiplier.
//   a mouse item runs a yaw wrap by repeated steps, two 16-step cordic
//   runs, six products, then three normalizations of three squares, a
//   32-step square root and three 15-step divisions.
//   an unused func code returns the current state.
// reset:
//   position goes to the start registers, yaw to -90 degrees, pitch to 0,
//   front (0,0,-1), up (0,1,0).
// stall:
//   the result sits in an output register until m_tready; the sequencer can
//   run the next item meanwhile and waits only to hand over its own result.
// ---------------------------------------------------------------------------
module euler_fly_camera_update_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // func[2:0], mouse_x[14:3], mouse_y[26:15]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // pos_x, pos_y, pos_z, front_x/y/z, up_x/y/z
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ecam_pkg::*;

    cfg_t      cfg;
    pos_load_t pos_load;
    result_t   result;

    ecam_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .pos_load (pos_load)
    );

    ecam_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pos_load  (pos_load),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .func      (s_tdata[2:0]),
        .mouse_x   (s_tdata[14:3]),
        .mouse_y   (s_tdata[26:15]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    assign m_tdata = {result.up_z, result.up_y, result.up_x,
                      result.front_z, result.front_y, result.front_x,
                      result.pos_z, result.pos_y, result.pos_x};

endmodule

>>> verif/ecam_checker.sv
// ---------------------------------------------------------------------------
// ecam_checker: result checker for the euler fly camera update unit
// tracks apb writes and accepted input items, predicts each result item
// in fixed point and compares it field by field with the block's output
// ---------------------------------------------------------------------------
module ecam_checker
    import ecam_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint wide_vec_t [3];
    typedef int     unit_vec_t [3];

    localparam longint D90  = 64'sd5898240;
    localparam longint D89  = 64'sd5832704;
    localparam longint D180 = 64'sd11796480;
    localparam longint D360 = 64'sd23592960;

    localparam longint ATAN_TAB [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117303, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic [19:0] step_len;
    logic [15:0] gain;
    logic [11:0] scr_w, scr_h;
    logic        up_neg;
    logic [31:0] cam_pos [3];
    int          yaw, pitch;
    unit_vec_t   front_v, right_v, up_v;

    result_t     expected_q [$];

    assign pending = expected_q.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic sin_cos(input longint ang, output longint c, output longint s);
        bit     flip;
        longint x, y, z, dx, dy;
        flip = 0;
        x = 64'sd652032874;
        y = 0;
        if (ang > D90)
        begin
            ang -= D180;
            flip = 1;
        end
        else if (ang < -D90)
        begin
            ang += D180;
            flip = 1;
        end
        z = ang;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic to_unit(input wide_vec_t v, output unit_vec_t o);
        logic [63:0] mag [3];
        logic [63:0] sum, m, q;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = v[k] < 0 ? -v[k] : v[k];
            sum += mag[k] * mag[k];
        end
        m = int_sqrt(sum);
        for (int k = 0; k < 3; k++)
        begin
            if (m == 0)
                o[k] = 0;
            else
            begin
                q = (mag[k] * 16384 + m / 2) / m;
                if (q > 16384)
                    q = 16384;
                o[k] = v[k] < 0 ? -int'(q) : int'(q);
            end
        end
    endtask

    task automatic rebuild_axes();
        longint    cy, sy, cp, sp, w;
        wide_vec_t f, r, u;
        w = up_neg ? -1 : 1;
        sin_cos(yaw, cy, sy);
        sin_cos(pitch, cp, sp);
        f[0] = (cy * cp) >>> 30;
        f[1] = sp;
        f[2] = (sy * cp) >>> 30;
        r[0] = -w * f[2];
        r[1] = 0;
        r[2] = w * f[0];
        u[0] = (r[1] * f[2] - r[2] * f[1]) >>> 30;
        u[1] = (r[2] * f[0] - r[0] * f[2]) >>> 30;
        u[2] = (r[0] * f[1] - r[1] * f[0]) >>> 30;
        to_unit(f, front_v);
        to_unit(r, right_v);
        to_unit(u, up_v);
    endtask

    task automatic move_along(input unit_vec_t d, input bit back);
        longint delta;
        for (int k = 0; k < 3; k++)
        begin
            delta = (longint'(d[k]) * longint'(step_len) + 8192) >>> 14;
            cam_pos[k] = back ? cam_pos[k] - delta[31:0] : cam_pos[k] + delta[31:0];
        end
    endtask

    task automatic turn_view(input logic [11:0] mx, input logic [11:0] my);
        longint dx2, dy2, ny, np;
        dx2 = 2 * longint'(mx) - longint'(scr_w);
        dy2 = longint'(scr_h) - 2 * longint'(my);
        ny = longint'(yaw) + ((dx2 * longint'(gain) + 1) >>> 1);
        np = longint'(pitch) + ((dy2 * longint'(gain) + 1) >>> 1);
        ny = (ny + D180) % D360;
        if (ny < 0)
            ny += D360;
        ny -= D180;
        if (np > D89)
            np = D89;
        if (np < -D89)
            np = -D89;
        yaw = int'(ny);
        pitch = int'(np);
        rebuild_axes();
    endtask

    function automatic result_t current_view();
        result_t r;
        r.pos_x = cam_pos[0];
        r.pos_y = cam_pos[1];
        r.pos_z = cam_pos[2];
        r.front_x = front_v[0][15:0];
        r.front_y = front_v[1][15:0];
        r.front_z = front_v[2][15:0];
        r.up_x = up_v[0][15:0];
        r.up_y = up_v[1][15:0];
        r.up_z = up_v[2][15:0];
        return r;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t unexpected result item", $realtime);
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
        if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
        if (got.front_x !== want.front_x) report("front_x", got.front_x, want.front_x);
        if (got.front_y !== want.front_y) report("front_y", got.front_y, want.front_y);
        if (got.front_z !== want.front_z) report("front_z", got.front_z, want.front_z);
        if (got.up_x !== want.up_x) report("up_x", got.up_x, want.up_x);
        if (got.up_y !== want.up_y) report("up_y", got.up_y, want.up_y);
        if (got.up_z !== want.up_z) report("up_z", got.up_z, want.up_z);
    endtask

    initial
        fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_len = 20'd13107;
            gain = 16'd6554;
            scr_w = 12'd800;
            scr_h = 12'd600;
            up_neg = 0;
            cam_pos = '{32'd0, 32'd0, 32'd0};
            yaw = -int'(D90);
            pitch = 0;
            front_v = '{0, 0, -16384};
            right_v = '{16384, 0, 0};
            up_v = '{0, 16384, 0};
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_MOVE_STEP:  step_len = pwdata[19:0];
                    REG_MOUSE_GAIN: gain = pwdata[15:0];
                    REG_SCREEN_W:   scr_w = pwdata[11:0];
                    REG_SCREEN_H:   scr_h = pwdata[11:0];
                    REG_START_X:    cam_pos[0] = pwdata;
                    REG_START_Y:    cam_pos[1] = pwdata;
                    REG_START_Z:    cam_pos[2] = pwdata;
                    REG_WORLD_UP:   up_neg = pwdata[0];
                endcase
            end
            if (m_tvalid && m_tready)
                check_result(result_t'(m_tdata));
            if (s_tvalid && s_tready)
            begin
                case (s_tdata[2:0])
                    FN_FORWARD:  move_along(front_v, 0);
                    FN_BACKWARD: move_along(front_v, 1);
                    FN_LEFT:     move_along(right_v, 1);
                    FN_RIGHT:    move_along(right_v, 0);
                    FN_MOUSE:    turn_view(s_tdata[14:3], s_tdata[26:15]);
                    default:     ;
                endcase
                expected_q = {expected_q, current_view()};
            end
        end
    end

endmodule

>>> verif/tb_euler_fly_camera_update_unit.sv
// ---------------------------------------------------------------------------
// tb_euler_fly_camera_update_unit: testbench of the fly camera update unit
// directed and random move, mouse and unused func code items under several
// settings and handshake idling patterns, results checked by ecam_checker
// ---------------------------------------------------------------------------
module tb_euler_fly_camera_update_unit;
    import ecam_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 116;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // func[2:0], mouse_x[14:3], mouse_y[26:15]
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;   // pos_x, pos_y, pos_z, front_x/y/z, up_x/y/z
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;

    euler_fly_camera_update_unit u_top (.*);

    ecam_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    initial
        clk = 0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    task automatic send_item(input logic [2:0] fn, input logic [11:0] mx,
                             input logic [11:0] my);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {5'd0, my, mx, fn};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        s_tvalid <= 0;
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_phase(input int ph);
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
        if (ph == 1)
        begin
            write_reg(REG_MOVE_STEP, 32'hFFFFF);
            write_reg(REG_MOUSE_GAIN, 32'hFFFF);
            write_reg(REG_SCREEN_W, 32'd4095);
            write_reg(REG_SCREEN_H, 32'd4095);
            write_reg(REG_START_X, 32'h7FFFFFFF);
            write_reg(REG_START_Y, 32'h80000000);
            write_reg(REG_START_Z, 32'h7FFF0000);
            write_reg(REG_WORLD_UP, 32'd1);
        end
        else if (ph == 2)
        begin
            write_reg(REG_MOVE_STEP, 32'd0);
            write_reg(REG_MOUSE_GAIN, 32'd0);
            write_reg(REG_SCREEN_W, 32'd1);
            write_reg(REG_SCREEN_H, 32'd1);
            write_reg(REG_START_X, 32'd0);
            write_reg(REG_START_Y, 32'hFFFFFFFF);
            write_reg(REG_START_Z, 32'd0);
            write_reg(REG_WORLD_UP, 32'd0);
        end
        else if (ph > 2)
        begin
            write_reg(REG_MOVE_STEP, $urandom_range(20'hFFFFF));
            write_reg(REG_MOUSE_GAIN, ($urandom_range(1)) ? $urandom_range(16'hFFFF)
                                                          : $urandom_range(8000));
            write_reg(REG_SCREEN_W, $urandom_range(4095, 1));
            write_reg(REG_SCREEN_H, $urandom_range(4095, 1));
            write_reg(REG_START_X, $urandom());
            write_reg(REG_START_Y, $urandom());
            write_reg(REG_START_Z, $urandom());
            write_reg(REG_WORLD_UP, $urandom_range(1));
        end
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send_item(FN_MOUSE, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        else if (pick < 92)
            send_item(3'($urandom_range(FN_RIGHT)), 12'($urandom_range(4095)),
                      12'($urandom_range(4095)));
        else
            send_item(3'($urandom_range(7, 5)), 12'($urandom_range(4095)),
                      12'($urandom_range(4095)));
    endtask

    initial
    begin
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 1;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: every func code, then mouse corners, pitch clamp and yaw wrap
        for (int f = 0; f < 8; f++)
            send_item(f[2:0], 12'hFFF, 12'h000);
        send_item(FN_MOUSE, 12'd0, 12'd0);
        send_item(FN_MOUSE, 12'd0, 12'd0);
        send_item(FN_MOUSE, 12'd4095, 12'd4095);
        send_item(FN_MOUSE, 12'd4095, 12'd4095);
        send_item(FN_MOUSE, 12'd400, 12'd300);
        send_item(FN_MOUSE, 12'd4095, 12'd0);
        send_item(FN_MOUSE, 12'd0, 12'd4095);
        send_item(FN_MOUSE, 12'd2000, 12'd300);
        send_item(FN_FORWARD, 12'd0, 12'd0);
        send_item(FN_BACKWARD, 12'd0, 12'd0);
        send_item(FN_LEFT, 12'd0, 12'd0);
        send_item(FN_RIGHT, 12'd0, 12'd0);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_phase(ph);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_item();
            drain();
        end

        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> euler_fly_camera_update_unit.f
rtl/core/ecam_pkg.sv
rtl/core/ecam_mul.sv
rtl/core/ecam_regs.sv
rtl/core/ecam_core.sv
rtl/core/euler_fly_camera_update_unit.sv
verif/ecam_checker.sv
verif/tb_euler_fly_camera_update_unit.sv
